FILE: rtl/tvck_pkg.sv
// shared types and constants for the two-mode-kept tensor contraction block
// no dependencies
package tvck_pkg;
    localparam int NMODES    = 6;
    localparam int MAXLEN    = 128;
    localparam int IDX_W     = 7;
    localparam int ACC_W     = 48;
    localparam int ENTRIES   = MAXLEN * MAXLEN;
    localparam int ADDR_W    = 14;
    localparam int VADDR_W   = 10;
    localparam int VDEPTH    = NMODES * MAXLEN;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_TENSOR = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        REG_LEN0 = 4'd0, REG_LEN1 = 4'd1, REG_LEN2 = 4'd2, REG_LEN3 = 4'd3,
        REG_LEN4 = 4'd4, REG_LEN5 = 4'd5, REG_FIRST = 4'd6, REG_SECOND = 4'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_RUN   = 2'd1
    } state_t;

    // q1.15 product, floor, saturate
    function automatic logic signed [15:0] qmul(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        logic signed [31:0] p;
        logic signed [16:0] q;
        begin
            p = a * b;
            q = p[31:15];
            if (q > 17'sd32767) qmul = 16'sh7fff;
            else qmul = q[15:0];
        end
    endfunction
endpackage

FILE: rtl/tensor_vector_contraction_keep_two.sv
// top level of the two-mode-kept tensor contraction: vector store, block
// accumulator memory, counters and the multiply/accumulate sequencer; uses tvck_pkg
//
// channel | dir | tdata fields (low bit first)                           | tuser
// s_      | in  | cmd[1:0] mode_sel[4:2] row[11:5] col[18:12] val[34:19] | -
// m_      | out | read_data[47:0] overflow[48] mode_error[49]             | -
//
// a tensor element runs four multiplies through the single vector read port, the
// block read landing with the last, then one write; no transaction is taken until
// the write is done. a read goes through rd_wait_reg and rd_done_reg to the output
// register, s_tready low while rd_wait_reg is set; a read also waits while a result
// sits in the output register. after reset and each clear, a pass zeroes the block
// memory with s_tready low. reset is synchronous, active low.
module tensor_vector_contraction_keep_two (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cmd, mode_sel, row_index, col_index, sample_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // read_data, overflow, mode_error
);
    logic [7:0] len_reg [tvck_pkg::NMODES];
    logic [2:0] first_reg, second_reg;
    logic mode_bad;
    assign mode_bad = (first_reg > 3'd5) || (second_reg > 3'd5) || (first_reg >= second_reg);

    tvck_pkg::cmd_t     in_cmd;
    logic [2:0]         in_sel;
    logic [6:0]         in_row, in_col;
    logic signed [15:0] in_val;
    assign in_cmd = tvck_pkg::cmd_t'(s_tdata[1:0]);
    assign in_sel = s_tdata[4:2];
    assign in_row = s_tdata[11:5];
    assign in_col = s_tdata[18:12];
    assign in_val = s_tdata[34:19];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tvck_pkg::NMODES; i++) len_reg[i] <= 8'd1;
            first_reg  <= 3'd0;
            second_reg <= 3'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                3'(tvck_pkg::REG_FIRST):  first_reg  <= cfg_data[2:0];
                3'(tvck_pkg::REG_SECOND): second_reg <= cfg_data[2:0];
                default: len_reg[cfg_index] <= cfg_data;
            endcase
        end
    end

    // memories
    logic signed [15:0] vmem [tvck_pkg::VDEPTH];
    logic [tvck_pkg::ACC_W-1:0] amem [tvck_pkg::ENTRIES];

    // control
    tvck_pkg::state_t state_reg, state_next;
    logic [tvck_pkg::ADDR_W:0] clr_reg;
    logic [tvck_pkg::IDX_W-1:0] pos_reg [tvck_pkg::NMODES];
    logic ovf_reg;

    // element sequencer: one contracted mode multiplied per cycle
    logic                        mul_reg;
    logic [1:0]                  mcnt_reg;
    logic                        wr_reg;
    logic signed [15:0]          mv_reg;
    logic signed [15:0]          vr_reg;
    logic [tvck_pkg::IDX_W-1:0]  ppos_reg [tvck_pkg::NMODES];
    logic [tvck_pkg::ADDR_W-1:0] paddr_reg;
    logic [2:0]                  cmode [4];
    logic [tvck_pkg::ACC_W-1:0]  ard_reg, wdata;
    logic                        sat_hit;

    // list of contracted modes in order
    always_comb begin
        int k;
        k = 0;
        for (int i = 0; i < 4; i++) cmode[i] = 3'd0;
        for (int m = 0; m < tvck_pkg::NMODES; m++) begin
            if (3'(m) != first_reg && 3'(m) != second_reg && k < 4) begin
                cmode[k[1:0]] = 3'(m);
                k = k + 1;
            end
        end
    end

    logic busy, rd_wait_reg, rd_done_reg, out_full, acc;
    assign busy = mul_reg | wr_reg;
    assign out_full = m_tvalid | rd_done_reg;
    assign acc = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        s_tready = 1'b0;
        case (state_reg)
            tvck_pkg::ST_CLEAR: if (clr_reg[tvck_pkg::ADDR_W]) state_next = tvck_pkg::ST_RUN;
            tvck_pkg::ST_RUN: begin
                // an element in flight holds off every transaction
                s_tready = !rd_wait_reg && !busy &&
                           !(in_cmd == tvck_pkg::CMD_READ && out_full);
                if (s_tvalid && s_tready && in_cmd == tvck_pkg::CMD_CLEAR)
                    state_next = tvck_pkg::ST_CLEAR;
            end
            default: state_next = tvck_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= tvck_pkg::ST_CLEAR;
        else state_reg <= state_next;
    end

    logic [7:0] eff [tvck_pkg::NMODES];
    always_comb begin
        for (int m = 0; m < tvck_pkg::NMODES; m++) begin
            if (len_reg[m] == 8'd0) eff[m] = 8'd1;
            else if (len_reg[m] > 8'd128) eff[m] = 8'd128;
            else eff[m] = len_reg[m];
        end
    end

    logic [tvck_pkg::IDX_W-1:0] pos_next [tvck_pkg::NMODES];
    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int m = tvck_pkg::NMODES - 1; m >= 0; m--) begin
            pos_next[m] = pos_reg[m];
            if (carry) begin
                if ({1'b0, pos_reg[m]} + 8'd1 >= eff[m]) pos_next[m] = 7'd0;
                else begin
                    pos_next[m] = pos_reg[m] + 7'd1;
                    carry = 1'b0;
                end
            end
        end
    end

    logic start;
    assign start = acc && in_cmd == tvck_pkg::CMD_TENSOR && !mode_bad;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            ovf_reg     <= 1'b0;
            rd_wait_reg <= 1'b0;
            mul_reg     <= 1'b0;
            mcnt_reg    <= 2'd0;
            wr_reg      <= 1'b0;
            for (int m = 0; m < tvck_pkg::NMODES; m++) pos_reg[m] <= 7'd0;
        end else begin
            if (state_reg == tvck_pkg::ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            else clr_reg <= '0;
            if (acc && in_cmd == tvck_pkg::CMD_CLEAR) begin
                ovf_reg <= 1'b0;
                for (int m = 0; m < tvck_pkg::NMODES; m++) pos_reg[m] <= 7'd0;
            end
            if (start) pos_reg <= pos_next;
            rd_wait_reg <= acc && in_cmd == tvck_pkg::CMD_READ;
            // four multiplies; the block read lands with the last one, write follows
            if (start) begin
                mul_reg  <= 1'b1;
                mcnt_reg <= 2'd0;
            end else if (mul_reg) begin
                mcnt_reg <= mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3) mul_reg <= 1'b0;
            end
            wr_reg <= mul_reg && mcnt_reg == 2'd3;
            if (wr_reg && sat_hit) ovf_reg <= 1'b1;
        end
    end

    // element payload
    always_ff @(posedge aclk) begin
        if (start) begin
            mv_reg    <= in_val;
            ppos_reg  <= pos_reg;
            paddr_reg <= {pos_reg[first_reg], pos_reg[second_reg]};
        end else if (mul_reg) begin
            mv_reg <= tvck_pkg::qmul(mv_reg, vr_reg);
        end
    end

    // vector store: one read port, the entry for the next multiply
    logic [1:0]                 vslot;
    logic [2:0]                 vmode;
    logic [tvck_pkg::IDX_W-1:0] vpos;
    assign vslot = mul_reg ? mcnt_reg + 2'd1 : 2'd0;
    assign vmode = cmode[vslot];
    assign vpos  = mul_reg ? ppos_reg[vmode] : pos_reg[vmode];
    always_ff @(posedge aclk) begin
        if (acc && in_cmd == tvck_pkg::CMD_LOAD && in_sel < 3'(tvck_pkg::NMODES))
            vmem[{in_sel, in_row}] <= in_val;
        vr_reg <= vmem[{vmode, vpos}];
    end

    // block memory: read with the last multiply, write in the cycle after
    logic [tvck_pkg::ADDR_W-1:0] rd_addr;
    logic [6:0] rr_reg, rc_reg;
    always_ff @(posedge aclk) begin
        if (acc) begin
            rr_reg <= in_row;
            rc_reg <= in_col;
        end
    end
    assign rd_addr = rd_wait_reg ? {rr_reg, rc_reg} : paddr_reg;

    logic signed [tvck_pkg::ACC_W:0] sum;
    always_comb begin
        sum = $signed({ard_reg[tvck_pkg::ACC_W-1], ard_reg}) + (tvck_pkg::ACC_W+1)'(mv_reg);
        sat_hit = sum[tvck_pkg::ACC_W] != sum[tvck_pkg::ACC_W-1];
        if (!sat_hit) wdata = sum[tvck_pkg::ACC_W-1:0];
        else if (sum[tvck_pkg::ACC_W]) wdata = {1'b1, {(tvck_pkg::ACC_W-1){1'b0}}};
        else wdata = {1'b0, {(tvck_pkg::ACC_W-1){1'b1}}};
    end
    always_ff @(posedge aclk) begin
        if (state_reg == tvck_pkg::ST_CLEAR)
            amem[clr_reg[tvck_pkg::ADDR_W-1:0]] <= '0;
        else if (wr_reg)
            amem[paddr_reg] <= wdata;
        ard_reg <= amem[rd_addr];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
            rd_done_reg <= 1'b0;
        end else begin
            rd_done_reg <= rd_wait_reg;
            if (rd_done_reg) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (rd_done_reg) m_tdata <= {6'd0, mode_bad, ovf_reg, ard_reg};
    end
endmodule

FILE: bench/tensor_vector_contraction_keep_two_checker.sv
// checker for the two-mode-kept tensor contraction: watches config writes and both
// channels, keeps its own contraction state and compares every read result
// depends on tvck_pkg
module tensor_vector_contraction_keep_two_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          errors,
    output int          pending
);
    typedef struct packed {
        logic [47:0] read_data;
        logic        overflow;
        logic        mode_error;
    } block_read_t;

    localparam longint ACC_MAX = (longint'(1) << (tvck_pkg::ACC_W - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    logic [7:0]         len_reg [tvck_pkg::NMODES];
    logic [2:0]         kept_row, kept_col;
    logic signed [15:0] vec_mem [tvck_pkg::NMODES * tvck_pkg::MAXLEN];
    longint             block_acc [tvck_pkg::ENTRIES];
    int unsigned        pos [tvck_pkg::NMODES];
    logic               ovf;
    block_read_t        read_q[$];

    function automatic int unsigned len_of(input int m);
        if (len_reg[m] == 0) return 1;
        if (len_reg[m] > tvck_pkg::MAXLEN) return tvck_pkg::MAXLEN;
        return len_reg[m];
    endfunction

    function automatic logic modes_invalid();
        return kept_row > 5 || kept_col > 5 || kept_row >= kept_col;
    endfunction

    // q1.15 product, floor shift, clamp at the top only
    function automatic logic signed [15:0] q15_mul(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        longint p;
        longint q;
        p = longint'(a) * longint'(b);
        q = p >>> 15;
        if (q > 32767) q = 32767;
        return q[15:0];
    endfunction

    task automatic contract_element(input logic signed [15:0] x);
        logic signed [15:0] v;
        int unsigned        idx;
        longint             acc;
        longint             add;
        v = x;
        for (int m = 0; m < tvck_pkg::NMODES; m++) begin
            if (m != kept_row && m != kept_col)
                v = q15_mul(v, vec_mem[m * tvck_pkg::MAXLEN + (pos[m] % tvck_pkg::MAXLEN)]);
        end
        idx = (pos[kept_row] % tvck_pkg::MAXLEN) * tvck_pkg::MAXLEN
              + (pos[kept_col] % tvck_pkg::MAXLEN);
        acc = block_acc[idx];
        add = longint'(v);
        if (add > 0 && acc > ACC_MAX - add) begin
            acc = ACC_MAX;
            ovf = 1'b1;
        end else if (add < 0 && acc < ACC_MIN - add) begin
            acc = ACC_MIN;
            ovf = 1'b1;
        end else begin
            acc = acc + add;
        end
        block_acc[idx] = acc;
        for (int m = tvck_pkg::NMODES - 1; m >= 0; m--) begin
            if (pos[m] + 1 >= len_of(m)) begin
                pos[m] = 0;
            end else begin
                pos[m]++;
                break;
            end
        end
    endtask

    always @(posedge aclk) begin
        tvck_pkg::cmd_t     cmd;
        logic [2:0]         sel;
        logic [6:0]         row, col;
        logic signed [15:0] val;
        block_read_t        exp_r, got;
        if (!aresetn) begin
            foreach (len_reg[m]) len_reg[m] = 8'd1;
            kept_row = 3'd0;
            kept_col = 3'd1;
            foreach (vec_mem[i]) vec_mem[i] = '0;
            foreach (block_acc[i]) block_acc[i] = 0;
            foreach (pos[m]) pos[m] = 0;
            ovf = 1'b0;
            read_q.delete();
        end else begin
            if (cfg_we) begin
                case (tvck_pkg::reg_idx_t'({1'b0, cfg_index}))
                    tvck_pkg::REG_FIRST:  kept_row = cfg_data[2:0];
                    tvck_pkg::REG_SECOND: kept_col = cfg_data[2:0];
                    default:              len_reg[cfg_index] = cfg_data;
                endcase
            end
            if (s_tvalid && s_tready) begin
                cmd = tvck_pkg::cmd_t'(s_tdata[1:0]);
                sel = s_tdata[4:2];
                row = s_tdata[11:5];
                col = s_tdata[18:12];
                val = s_tdata[34:19];
                case (cmd)
                    tvck_pkg::CMD_LOAD:
                        if (sel < tvck_pkg::NMODES) vec_mem[sel * tvck_pkg::MAXLEN + row] = val;
                    tvck_pkg::CMD_TENSOR: if (!modes_invalid()) contract_element(val);
                    tvck_pkg::CMD_CLEAR: begin
                        foreach (block_acc[i]) block_acc[i] = 0;
                        foreach (pos[m]) pos[m] = 0;
                        ovf = 1'b0;
                    end
                    tvck_pkg::CMD_READ: begin
                        exp_r.read_data  = block_acc[row * tvck_pkg::MAXLEN + col][47:0];
                        exp_r.overflow   = ovf;
                        exp_r.mode_error = modes_invalid();
                        read_q = {read_q, exp_r};
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.read_data  = m_tdata[47:0];
                got.overflow   = m_tdata[48];
                got.mode_error = m_tdata[49];
                if (read_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, actual %h", $time, got);
                    errors++;
                end else begin
                    exp_r = read_q.pop_front();
                    if (got.read_data !== exp_r.read_data) begin
                        $display("%0t: read_data expected %h actual %h", $time,
                                 exp_r.read_data, got.read_data);
                        errors++;
                    end
                    if (got.overflow !== exp_r.overflow) begin
                        $display("%0t: overflow expected %b actual %b", $time,
                                 exp_r.overflow, got.overflow);
                        errors++;
                    end
                    if (got.mode_error !== exp_r.mode_error) begin
                        $display("%0t: mode_error expected %b actual %b", $time,
                                 exp_r.mode_error, got.mode_error);
                        errors++;
                    end
                end
            end
        end
        pending = read_q.size();
    end

    initial begin
        errors  = 0;
        pending = 0;
    end
endmodule

FILE: bench/tensor_vector_contraction_keep_two_tb.sv
// testbench top for the two-mode-kept tensor contraction: clock, reset, config
// phases, directed and random stimulus, flow control and verdict
// depends on tvck_pkg, the block and tensor_vector_contraction_keep_two_checker
module tensor_vector_contraction_keep_two_tb;
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    int          errors;
    int          pending;

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;
    logic [7:0]  len_set [tvck_pkg::NMODES];
    int          vec_hi [tvck_pkg::NMODES];
    bit          vec_written [tvck_pkg::NMODES][tvck_pkg::MAXLEN];
    int          sent;

    always #1 aclk = ~aclk;

    tensor_vector_contraction_keep_two dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    tensor_vector_contraction_keep_two_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    // receiver flow control, with one long hold-off on request
    initial begin
        int hold_left;
        m_tready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && hold_left == 0) begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_item(input tvck_pkg::cmd_t cmd, input logic [2:0] sel,
                             input logic [6:0] row, input logic [6:0] col,
                             input logic [15:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, val, col, row, sel, cmd};
        do @(posedge aclk); while (!s_tready);
        if (cmd == tvck_pkg::CMD_LOAD && sel < tvck_pkg::NMODES) vec_written[sel][row] = 1'b1;
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // block is idle here; every register is written
    task automatic write_config(input logic [2:0] kr, input logic [2:0] kc);
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= (i < tvck_pkg::NMODES) ? len_set[i]
                       : ((i == tvck_pkg::REG_FIRST) ? {5'd0, kr} : {5'd0, kc});
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        for (int m = 0; m < tvck_pkg::NMODES; m++) begin
            int e;
            e = (len_set[m] == 0) ? 1
              : ((len_set[m] > tvck_pkg::MAXLEN) ? tvck_pkg::MAXLEN : len_set[m]);
            if (e > vec_hi[m]) vec_hi[m] = e;
        end
    endtask

    // every vector entry a position counter can reach must be loaded
    task automatic fill_vectors();
        for (int m = 0; m < tvck_pkg::NMODES; m++)
            for (int i = 0; i < vec_hi[m]; i++)
                if (!vec_written[m][i])
                    send_item(tvck_pkg::CMD_LOAD, m[2:0], i[6:0], 7'($urandom),
                              16'($urandom));
    endtask

    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 80) return 8'($urandom_range(1, 4));
        if (r < 88) return 8'd0;
        if (r < 94) return 8'($urandom_range(129, 255));
        return 8'($urandom_range(5, 128));
    endfunction

    task automatic random_item(input int sig_pct);
        int          r;
        logic [15:0] v;
        r = $urandom_range(99);
        v = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'h8000 : 16'h7fff)
                                     : 16'($urandom);
        if (r < 60) begin
            send_item(tvck_pkg::CMD_TENSOR, 3'($urandom), 7'($urandom), 7'($urandom), v);
        end else if (r < 85) begin
            if ($urandom_range(3) != 0)
                send_item(tvck_pkg::CMD_READ, 3'($urandom), 7'($urandom_range(7)),
                          7'($urandom_range(7)), 16'($urandom));
            else
                send_item(tvck_pkg::CMD_READ, 3'($urandom), 7'($urandom), 7'($urandom),
                          16'($urandom));
        end else if (r < 99 || sig_pct == 0) begin
            send_item(tvck_pkg::CMD_LOAD, 3'($urandom), 7'($urandom), 7'($urandom), v);
        end else begin
            send_item(tvck_pkg::CMD_CLEAR, 3'($urandom), 7'($urandom), 7'($urandom),
                      16'($urandom));
        end
    endtask

    initial begin
        int          phase;
        logic [2:0]  kr, kc;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        hold_req  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sent = 0;
        foreach (vec_hi[m]) vec_hi[m] = 1;
        foreach (len_set[m]) len_set[m] = 8'd1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes of the q1.15 product and the ignored cases
        for (int m = 0; m < tvck_pkg::NMODES; m++)
            send_item(tvck_pkg::CMD_LOAD, m[2:0], 7'd0, 7'd0, 16'h8000);
        send_item(tvck_pkg::CMD_LOAD, 3'd7, 7'd127, 7'd127, 16'h1234);
        send_item(tvck_pkg::CMD_TENSOR, 3'd0, 7'd0, 7'd0, 16'h8000);
        send_item(tvck_pkg::CMD_TENSOR, 3'd0, 7'd0, 7'd0, 16'h7fff);
        send_item(tvck_pkg::CMD_TENSOR, 3'd0, 7'd0, 7'd0, 16'hffff);
        send_item(tvck_pkg::CMD_READ, 3'd0, 7'd0, 7'd0, 16'd0);
        send_item(tvck_pkg::CMD_READ, 3'd7, 7'd127, 7'd127, 16'hffff);
        send_item(tvck_pkg::CMD_LOAD, 3'd2, 7'd0, 7'd0, 16'h7fff);
        send_item(tvck_pkg::CMD_TENSOR, 3'd0, 7'd0, 7'd0, 16'h8000);
        send_item(tvck_pkg::CMD_READ, 3'd0, 7'd0, 7'd0, 16'd0);
        send_item(tvck_pkg::CMD_CLEAR, 3'd0, 7'd0, 7'd0, 16'd0);
        send_item(tvck_pkg::CMD_READ, 3'd0, 7'd0, 7'd0, 16'd0);
        wait_drained();
        len_set = '{8'd0, 8'd200, 8'd2, 8'd1, 8'd1, 8'd2};
        write_config(3'd5, 3'd5);
        fill_vectors();
        send_item(tvck_pkg::CMD_TENSOR, 3'd0, 7'd0, 7'd0, 16'h4000);
        send_item(tvck_pkg::CMD_READ, 3'd0, 7'd0, 7'd0, 16'd0);
        wait_drained();

        // random phases with changing idling and configuration
        phase = 0;
        while (sent < 1800) begin
            if (sent < 600) begin
                send_idle_pct = 24;
                recv_idle_pct = 46;
            end else if (sent < 1200) begin
                send_idle_pct = 46;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            foreach (len_set[m]) len_set[m] = pick_len();
            if (phase == 3) len_set = '{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128};
            if (phase == 4) len_set = '{8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1};
            if ($urandom_range(9) == 0) begin
                kr = 3'($urandom);
                kc = 3'($urandom);
            end else begin
                kc = 3'($urandom_range(1, 5));
                kr = 3'($urandom_range(0, kc - 1));
            end
            if (phase == 2) begin
                kr = 3'd4;
                kc = 3'd5;
            end
            write_config(kr, kc);
            fill_vectors();
            if (phase % 4 == 1)
                send_item(tvck_pkg::CMD_CLEAR, 3'd0, 7'd0, 7'd0, 16'd0);
            if (phase == 6) hold_req = 1'b1;
            for (int k = 0; k < 60; k++)
                random_item(phase % 5 == 0 ? 1 : 0);
            send_item(tvck_pkg::CMD_READ, 3'd0, 7'($urandom_range(3)),
                      7'($urandom_range(3)), 16'd0);
            wait_drained();
            phase++;
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: sim.f
rtl/tvck_pkg.sv
rtl/tensor_vector_contraction_keep_two.sv
bench/tensor_vector_contraction_keep_two_checker.sv
bench/tensor_vector_contraction_keep_two_tb.sv
